@@ design/sparse_subset_position_map_defines.svh @@
// assertion macros shared by the checker
`ifndef SPARSE_SUBSET_POSITION_MAP_DEFINES_SVH
`define SPARSE_SUBSET_POSITION_MAP_DEFINES_SVH

// same-cycle implication
`define SSPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sspm check failed");

// next-cycle implication
`define SSPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sspm check failed");

`endif

@@ design/sspm_pkg.sv @@
`timescale 1ns / 1ps
package sspm_pkg;

  localparam int unsigned MAX_ROWS     = 1024;
  localparam int unsigned MAX_NONZEROS = 4096;
  localparam int unsigned COLUMN_BITS  = 24;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned START_W    = 13;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ROW_ADDR_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned COL_ADDR_W = $clog2(MAX_NONZEROS);

  localparam logic [OP_W-1:0] OP_LOAD_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_COLUMN = 2'd1;
  localparam logic [OP_W-1:0] OP_MAP         = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [ROW_W-1:0]       row;
    logic [IDX_W-1:0]       entry_index;
    logic [COLUMN_BITS-1:0] column;
    logic [START_W-1:0]     offset;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    y_position;
    logic [STATUS_W-1:0] status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ROW_SETUP,
    S_COL_READ,
    S_COL_CMP,
    S_RESPOND
  } state_t;

  typedef struct packed {
    logic                capture;
    logic                load_write;
    logic                row_read;
    logic                row_setup;
    logic                col_read;
    logic                cursor_step;
    logic                set_result;
    logic [STATUS_W-1:0] result_status;
    logic                use_pos;
    logic                push;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load_bad;
    logic            map_bad;
    logic            at_bound;
    logic            col_less;
    logic            col_equal;
    logic            out_free;
  } dp_status_t;

endpackage

@@ design/sspm_ctrl.sv @@
`timescale 1ns / 1ps
module sspm_ctrl
  import sspm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_status_t status,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (status.op == OP_MAP && !status.map_bad) state_next = S_ROW_SETUP;
        else state_next = S_RESPOND;
      end
      S_ROW_SETUP: begin
        state_next = S_COL_READ;
      end
      S_COL_READ: begin
        if (status.at_bound) state_next = S_RESPOND;
        else state_next = S_COL_CMP;
      end
      S_COL_CMP: begin
        if (status.col_less) state_next = S_COL_READ;
        else state_next = S_RESPOND;
      end
      S_RESPOND: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        item_stall  = 1'b0;
        cmd.capture = item_valid;
      end
      S_EXEC: begin
        unique case (status.op) inside
          OP_LOAD_START, OP_LOAD_COLUMN: begin
            cmd.load_write    = 1'b1;
            cmd.set_result    = 1'b1;
            cmd.result_status = status.load_bad ? ST_RANGE : ST_OK;
          end
          OP_MAP: begin
            if (status.map_bad) begin
              cmd.set_result    = 1'b1;
              cmd.result_status = ST_RANGE;
            end else begin
              cmd.row_read = 1'b1;
            end
          end
          default: begin
            cmd.set_result    = 1'b1;
            cmd.result_status = ST_OK;
          end
        endcase
      end
      S_ROW_SETUP: begin
        cmd.row_setup = 1'b1;
      end
      S_COL_READ: begin
        if (status.at_bound) begin
          cmd.set_result    = 1'b1;
          cmd.result_status = ST_NOT_FOUND;
        end else begin
          cmd.col_read = 1'b1;
        end
      end
      S_COL_CMP: begin
        if (status.col_less) begin
          cmd.cursor_step = 1'b1;
        end else if (status.col_equal) begin
          cmd.cursor_step   = 1'b1;
          cmd.set_result    = 1'b1;
          cmd.result_status = ST_OK;
          cmd.use_pos       = 1'b1;
        end else begin
          cmd.set_result    = 1'b1;
          cmd.result_status = ST_NOT_FOUND;
        end
      end
      S_RESPOND: begin
        cmd.push = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ design/sspm_dp.sv @@
`timescale 1ns / 1ps
module sspm_dp
  import sspm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  item_t            item_data,
  input  logic             cfg_write,
  input  logic [ROW_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output dp_status_t       status,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result_data
);

  item_t                   item;
  logic [ROW_W-1:0]        row_count;

  logic [START_W-1:0]      row_start_mem [MAX_ROWS+1];
  logic [COLUMN_BITS-1:0]  col_mem [MAX_NONZEROS];
  logic [START_W-1:0]      start_rd;
  logic [START_W-1:0]      bound_rd;
  logic [COLUMN_BITS-1:0]  col_rd;

  logic [ROW_W-1:0]        current_row;
  logic [START_W-1:0]      cursor;
  logic                    row_open;
  logic [START_W-1:0]      bound;

  logic [STATUS_W-1:0]     pend_status;
  logic [IDX_W-1:0]        pend_pos;

  logic [ROW_ADDR_W-1:0]   row_addr;
  logic [ROW_ADDR_W-1:0]   row_next_addr;
  logic                    start_bad;
  logic                    column_bad;

  assign row_addr      = item.row[ROW_ADDR_W-1:0];
  assign row_next_addr = row_addr + 1'b1;
  assign start_bad     = 32'(item.row) > MAX_ROWS;
  assign column_bad    = 32'(item.entry_index) >= MAX_NONZEROS;

  assign status.op        = item.operation;
  assign status.load_bad  = (item.operation == OP_LOAD_START) ? start_bad : column_bad;
  assign status.map_bad   = (item.row >= row_count) || (32'(item.row) >= MAX_ROWS);
  assign status.at_bound  = cursor >= bound;
  assign status.col_less  = col_rd < item.column;
  assign status.col_equal = col_rd == item.column;
  assign status.out_free  = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= item_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (cfg_write) begin
      row_count <= cfg_data;
    end
  end

  // row start store, one write and two reads
  always_ff @(posedge clk) begin
    if (cmd.load_write && item.operation == OP_LOAD_START && !start_bad) begin
      row_start_mem[row_addr] <= item.offset;
    end
    if (cmd.row_read) begin
      start_rd <= row_start_mem[row_addr];
      bound_rd <= row_start_mem[row_next_addr];
    end
  end

  // column store
  always_ff @(posedge clk) begin
    if (cmd.load_write && item.operation == OP_LOAD_COLUMN && !column_bad) begin
      col_mem[item.entry_index[COL_ADDR_W-1:0]] <= item.column;
    end
    if (cmd.col_read) begin
      col_rd <= col_mem[cursor[COL_ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_setup) begin
      bound <= (32'(bound_rd) > MAX_NONZEROS) ? START_W'(MAX_NONZEROS) : bound_rd;
    end
  end

  // row cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
      cursor      <= '0;
      row_open    <= 1'b0;
    end else begin
      if (cmd.load_write) begin
        row_open <= 1'b0;
      end else if (cmd.row_setup && (!row_open || item.row != current_row)) begin
        current_row <= item.row;
        cursor      <= start_rd;
        row_open    <= 1'b1;
      end else if (cmd.cursor_step) begin
        cursor <= cursor + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_result) begin
      pend_status <= cmd.result_status;
      pend_pos    <= cmd.use_pos ? cursor[IDX_W-1:0] : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      result_data.y_position <= pend_pos;
      result_data.status     <= pend_status;
    end
  end

endmodule

@@ design/sparse_subset_position_map.sv @@
`timescale 1ns / 1ps
// Maps each nonzero of a CSR matrix X to its storage position in a matrix Y
// whose pattern contains that of X. Y's row starts (op 0, including the end
// mark at row 1024) and sorted column indices (op 1) are loaded first; every
// store entry must be written before it is read, as the stores are not
// cleared. X entries (op 2) then arrive in row-major order with sorted
// columns, and a single cursor for the open row walks forward through Y's
// columns. One item is handled at a time. A load, op 3, or an out-of-range
// map goes from execute to respond; a map sets up the row, then reads and
// compares Y columns until one is not smaller or the row end is reached.
// Each compare step is paced by the registered read of the column store.
// A finished result sits in an output register, so the next item can be
// taken while it waits. The user writes row_count through the cfg port
// only while the block is idle; the block itself does not enforce it.
module sparse_subset_position_map
  import sspm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item_data,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ROW_W-1:0] cfg_data
);

  cmd_t       cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  sspm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  sspm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item_data    (item_data),
    .cfg_write    (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule

@@ design/sspm_checker.sv @@
`timescale 1ns / 1ps
`include "sparse_subset_position_map_defines.svh"
module sspm_checker
  import sspm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result_data
);

  logic in_transfer;
  logic error_out;
  logic out_waiting;

  assign in_transfer = item_valid && !item_stall;
  assign error_out   = result_valid && (result_data.status != ST_OK);
  assign out_waiting = result_valid && result_stall;

  // one item in flight
  `SSPM_ASSERT_NEXT(a_busy_after_transfer, in_transfer, item_stall)

  `SSPM_ASSERT_NOW(a_status_known, result_valid, result_data.status <= ST_RANGE)

  `SSPM_ASSERT_NOW(a_position_zero_on_error, error_out, result_data.y_position == '0)

  `SSPM_ASSERT_NEXT(a_result_held, out_waiting, result_valid && $stable(result_data))

endmodule

bind sparse_subset_position_map sspm_checker u_sspm_checker (.*);
